### rtl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared constants and controller/datapath command and status types for the
// cubic Bezier trajectory core.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

   localparam int COORD_WIDTH_DEF = 20;

   localparam int N_WIDTH     = 6;
   localparam int T_WIDTH     = 17;
   localparam int ONE_INT     = 65536;
   localparam int SAMPLES_INT = 16;

   localparam int HELD_DEPTH   = 3;
   localparam int HELD_IDX_W   = 2;
   localparam int DIV_STEPS    = T_WIDTH;
   localparam int WEIGHT_SHIFT = 32;
   localparam int ROUND_SHIFT  = 16;

   localparam logic [N_WIDTH-1:0] SAMPLES_RESET = N_WIDTH'(SAMPLES_INT);
   localparam logic [T_WIDTH-1:0] ONE_Q16       = T_WIDTH'(ONE_INT);
   localparam logic [T_WIDTH-1:0] QUO_RESET     = T_WIDTH'(ONE_INT / SAMPLES_INT);
   localparam logic [N_WIDTH-1:0] REM_RESET     = N_WIDTH'(ONE_INT % SAMPLES_INT);

   typedef struct packed {
      logic                  store;
      logic [HELD_IDX_W-1:0] store_idx;
      logic                  seg_load;
      logic                  div_step;
      logic                  issue;
      logic                  issue_first;
      logic                  issue_last;
   } cmd_type;

   typedef struct packed {
      logic [N_WIDTH-1:0] n_eff;
      logic               pipe_busy;
      logic               adv;
   } status_type;

endpackage

`default_nettype wire

### rtl/cbt_channel_if.sv
// ----------------------------------------------------------------------------
// cbt_channel_if
// Valid/ready channels of the trajectory core: control point requests in,
// curve point results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbt_req_if #(parameter int COORD_WIDTH = cbt_pkg::COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          starts_path;

   modport source (output valid, output point_x, output point_y, output starts_path,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input starts_path,
                   output ready);
endinterface

interface cbt_rsp_if #(parameter int COORD_WIDTH = cbt_pkg::COORD_WIDTH_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] curve_x;
   logic signed [COORD_WIDTH-1:0] curve_y;
   logic                          segment_end;

   modport source (output valid, output curve_x, output curve_y, output segment_end,
                   input ready);
   modport sink   (input valid, input curve_x, input curve_y, input segment_end,
                   output ready);
endinterface

`default_nettype wire

### rtl/cbt_ctrl.sv
// ----------------------------------------------------------------------------
// cbt_ctrl
// Sequencer: tracks held control points, runs the t-step divider after a
// register write and issues one curve sample per unstalled cycle per segment.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire                         starts_path,
   input  wire                         csr_we,
   input  cbt_pkg::status_type         status,
   output cbt_pkg::cmd_type            cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_ISSUE  = 2'd2;

   localparam int NW = cbt_pkg::N_WIDTH;
   localparam int HW = cbt_pkg::HELD_IDX_W;

   logic [1:0]    state_ff, state_in;
   logic [HW-1:0] count_ff, count_in;
   logic [NW-1:0] idx_ff, idx_in;
   logic          last;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_ready = 1'b0;
      last      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !status.pipe_busy && !csr_we;
            if (csr_we) begin
               state_in = ST_DIVIDE;
               idx_in   = '0;
            end else if (req_valid && req_ready) begin
               if (starts_path) begin
                  cmd.store     = 1'b1;
                  cmd.store_idx = '0;
                  count_in      = HW'(1);
               end else if (count_ff != HW'(cbt_pkg::HELD_DEPTH)) begin
                  cmd.store     = 1'b1;
                  cmd.store_idx = count_ff;
                  count_in      = count_ff + HW'(1);
               end else begin
                  cmd.seg_load = 1'b1;
                  count_in     = HW'(1);
                  idx_in       = '0;
                  state_in     = ST_ISSUE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            idx_in       = idx_ff + NW'(1);
            if (idx_ff == NW'(cbt_pkg::DIV_STEPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            if (status.adv) begin
               last            = (idx_ff == status.n_eff);
               cmd.issue       = 1'b1;
               cmd.issue_first = (idx_ff == '0);
               cmd.issue_last  = last;
               idx_in          = idx_ff + NW'(1);
               if (last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

### rtl/cbt_datapath.sv
// ----------------------------------------------------------------------------
// cbt_datapath
// Point storage, bit-serial t-step divider, incremental t generator and the
// weight/blend pipeline ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_datapath #(
   parameter int COORD_WIDTH = cbt_pkg::COORD_WIDTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire        [cbt_pkg::N_WIDTH-1:0]   csr_wdata,
   input  wire signed [COORD_WIDTH-1:0]        point_x,
   input  wire signed [COORD_WIDTH-1:0]        point_y,
   input  cbt_pkg::cmd_type                    cmd,
   output cbt_pkg::status_type                 status,
   input  wire                                 rsp_ready,
   output logic                                rsp_valid,
   output logic signed [COORD_WIDTH-1:0]       curve_x,
   output logic signed [COORD_WIDTH-1:0]       curve_y,
   output logic                                segment_end
);

   localparam int CW   = COORD_WIDTH;
   localparam int NW   = cbt_pkg::N_WIDTH;
   localparam int TW   = cbt_pkg::T_WIDTH;
   localparam int SQW  = 2 * TW - 1;
   localparam int CUW  = 3 * TW - 2;
   localparam int W3W  = CUW + 2;
   localparam int WS   = cbt_pkg::WEIGHT_SHIFT;
   localparam int RS   = cbt_pkg::ROUND_SHIFT;
   localparam int MW   = CW + TW + 1;
   localparam int SW   = MW + 1;
   localparam int AW   = MW + 2;
   localparam int QW   = AW - RS;
   localparam int PIPE = 6;

   localparam logic [CUW-1:0] W_HALF  = CUW'(1) << (WS - 1);
   localparam logic [W3W-1:0] W3_HALF = W3W'(1) << (WS - 1);
   localparam logic [AW-1:0]  R_HALF  = AW'(1) << (RS - 1);

   // configuration and t-step divider
   logic [NW-1:0] samples_ff;
   logic [NW-1:0] n_eff;
   logic [TW-1:0] quo_ff;
   logic [NW-1:0] rem_ff;
   logic [TW-1:0] dvd_ff;
   logic [NW:0]   rem_sh;
   logic          div_ge;

   assign n_eff  = (samples_ff == '0) ? NW'(1) : samples_ff;
   assign rem_sh = {rem_ff, dvd_ff[TW-1]};
   assign div_ge = (rem_sh >= {1'b0, n_eff});

   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= cbt_pkg::SAMPLES_RESET;
         quo_ff     <= cbt_pkg::QUO_RESET;
         rem_ff     <= cbt_pkg::REM_RESET;
      end else if (csr_we) begin
         samples_ff <= csr_wdata;
         quo_ff     <= '0;
         rem_ff     <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[TW-2:0], div_ge};
         rem_ff <= div_ge ? NW'(rem_sh - {1'b0, n_eff}) : NW'(rem_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (csr_we) begin
         dvd_ff <= cbt_pkg::ONE_Q16;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[TW-2:0], 1'b0};
      end
   end

   // t = round(i * 1.0 / n), stepped by quotient and remainder
   logic [TW-1:0] tq_ff;
   logic [NW-1:0] tr_ff;
   logic [TW-1:0] t_cur;
   logic [NW-1:0] r_cur;
   logic [NW:0]   r_sum;
   logic          r_ge;

   assign t_cur = cmd.issue_first ? '0 : tq_ff;
   assign r_cur = cmd.issue_first ? (n_eff >> 1) : tr_ff;
   assign r_sum = {1'b0, r_cur} + {1'b0, rem_ff};
   assign r_ge  = (r_sum >= {1'b0, n_eff});

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         tq_ff <= t_cur + quo_ff + TW'(r_ge);
         tr_ff <= r_ge ? NW'(r_sum - {1'b0, n_eff}) : NW'(r_sum);
      end
   end

   // control point storage, index 0 is x, 1 is y
   logic signed [CW-1:0] pt [2];
   logic signed [CW-1:0] held_ff [2][3];
   logic signed [CW-1:0] seg_ff [2][4];

   assign pt[0] = point_x;
   assign pt[1] = point_y;

   always_ff @(posedge clock) begin
      for (int c = 0; c < 2; c++) begin
         if (cmd.store) begin
            held_ff[c][cmd.store_idx] <= pt[c];
         end
         if (cmd.seg_load) begin
            held_ff[c][0] <= pt[c];
            seg_ff[c][0]  <= held_ff[c][0];
            seg_ff[c][1]  <= held_ff[c][1];
            seg_ff[c][2]  <= held_ff[c][2];
            seg_ff[c][3]  <= pt[c];
         end
      end
   end

   // pipeline control
   logic [PIPE-1:0] valid_ff;
   logic [PIPE-1:0] end_ff;
   logic            rsp_valid_ff;
   logic            adv;

   assign adv = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[PIPE-2:0], cmd.issue};
         rsp_valid_ff <= valid_ff[PIPE-1];
      end
   end

   // stage 1: t, u
   logic [TW-1:0] t1_ff, u1_ff;
   // stage 2: squares
   logic [SQW-1:0] tt2_ff, uu2_ff;
   logic [TW-1:0]  t2_ff, u2_ff;
   // stage 3: cubes
   logic [CUW-1:0] uuu3_ff, tuu3_ff, ttu3_ff, ttt3_ff;
   // stage 4: weights
   logic [TW-1:0]  w_ff [4];
   // stage 5: products
   logic signed [MW-1:0] m_ff [2][4];
   // stage 6: pair sums
   logic signed [SW-1:0] s01_ff [2];
   logic signed [SW-1:0] s23_ff [2];
   // output
   logic signed [CW-1:0] out_ff [2];
   logic                 out_end_ff;

   logic [SQW-1:0] t1_wide, u1_wide;
   logic [CUW-1:0] t2_wide, u2_wide, tt2_wide, uu2_wide;
   logic [CUW-1:0] uuu_rnd, ttt_rnd;
   logic [W3W-1:0] tuu_rnd, ttu_rnd;

   assign t1_wide  = SQW'(t1_ff);
   assign u1_wide  = SQW'(u1_ff);
   assign t2_wide  = CUW'(t2_ff);
   assign u2_wide  = CUW'(u2_ff);
   assign tt2_wide = CUW'(tt2_ff);
   assign uu2_wide = CUW'(uu2_ff);
   assign uuu_rnd  = uuu3_ff + W_HALF;
   assign ttt_rnd  = ttt3_ff + W_HALF;
   assign tuu_rnd  = {tuu3_ff, 1'b0} + W3W'(tuu3_ff) + W3_HALF;
   assign ttu_rnd  = {ttu3_ff, 1'b0} + W3W'(ttu3_ff) + W3_HALF;

   logic signed [MW-1:0] p_wide [2][4];
   logic signed [MW-1:0] w_wide [4];
   logic signed [AW-1:0] acc    [2];
   logic signed [QW-1:0] q      [2];
   logic signed [CW-1:0] sat    [2];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         w_wide[k] = MW'({1'b0, w_ff[k]});
      end
      for (int c = 0; c < 2; c++) begin
         for (int k = 0; k < 4; k++) begin
            p_wide[c][k] = MW'(seg_ff[c][k]);
         end
         acc[c] = AW'(s01_ff[c]) + AW'(s23_ff[c]) + R_HALF;
         q[c]   = acc[c][AW-1:RS];
         if ((&q[c][QW-1:CW-1]) || !(|q[c][QW-1:CW-1])) begin
            sat[c] = q[c][CW-1:0];
         end else if (q[c][QW-1]) begin
            sat[c] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            sat[c] = {1'b0, {(CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff   <= t_cur;
         u1_ff   <= cbt_pkg::ONE_Q16 - t_cur;
         end_ff  <= {end_ff[PIPE-2:0], cmd.issue_last};

         tt2_ff  <= t1_wide * t1_wide;
         uu2_ff  <= u1_wide * u1_wide;
         t2_ff   <= t1_ff;
         u2_ff   <= u1_ff;

         uuu3_ff <= uu2_wide * u2_wide;
         tuu3_ff <= uu2_wide * t2_wide;
         ttu3_ff <= tt2_wide * u2_wide;
         ttt3_ff <= tt2_wide * t2_wide;

         w_ff[0] <= uuu_rnd[WS +: TW];
         w_ff[1] <= tuu_rnd[WS +: TW];
         w_ff[2] <= ttu_rnd[WS +: TW];
         w_ff[3] <= ttt_rnd[WS +: TW];

         for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 4; k++) begin
               m_ff[c][k] <= p_wide[c][k] * w_wide[k];
            end
            s01_ff[c] <= SW'(m_ff[c][0]) + SW'(m_ff[c][1]);
            s23_ff[c] <= SW'(m_ff[c][2]) + SW'(m_ff[c][3]);
            out_ff[c] <= sat[c];
         end
         out_end_ff <= end_ff[PIPE-1];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign curve_x     = out_ff[0];
   assign curve_y     = out_ff[1];
   assign segment_end = out_end_ff;

   assign status.n_eff     = n_eff;
   assign status.pipe_busy = |valid_ff;
   assign status.adv       = adv;

endmodule

`default_nettype wire

### rtl/cubic_bezier_trajectory_core.sv
// ----------------------------------------------------------------------------
// cubic_bezier_trajectory_core
// Piecewise cubic Bezier evaluation over a stream of 2D control points.
// ----------------------------------------------------------------------------
// A request that only stores a control point (fewer than three held, or a
// path start) updates the held points. A request that completes a segment
// starts samples_per_segment+1 curve samples (a value of 0 counts as 1),
// issued one per cycle, while the result side does not stall, into a
// seven-stage weight and blend pipeline; the next request is taken once
// the pipeline has drained into the result register.
// A write to the samples_per_segment register while idle runs a bit-serial
// divider, during which no request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_trajectory_core #(
   parameter int COORD_WIDTH = cbt_pkg::COORD_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   cbt_req_if.sink                          req_bus,
   cbt_rsp_if.source                        rsp_bus,
   input  wire                              csr_we,
   input  wire [cbt_pkg::N_WIDTH-1:0]       csr_wdata
);

   cbt_pkg::cmd_type    cmd;
   cbt_pkg::status_type status;

   cbt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .starts_path (req_bus.starts_path),
      .csr_we      (csr_we),
      .status      (status),
      .cmd         (cmd)
   );

   cbt_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .point_x     (req_bus.point_x),
      .point_y     (req_bus.point_y),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .curve_x     (rsp_bus.curve_x),
      .curve_y     (rsp_bus.curve_y),
      .segment_end (rsp_bus.segment_end)
   );

   a_div_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_bus.ready)
      else $error("request taken while divider runs");

   a_issue_needs_adv: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> status.adv)
      else $error("sample issued into stalled pipeline");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && rsp_bus.segment_end |-> !status.pipe_busy)
      else $error("samples in flight behind segment end");

endmodule

`default_nettype wire

### tb/cubic_bezier_trajectory_core_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_trajectory_core_tb
// Streams control points through the trajectory core over the valid/ready
// channels. A scoreboard evaluates each completed cubic segment in Q1.16
// Bernstein weights and compares every curve point in order. The interval
// count register is stepped through zero, one, the top value and others.
// ----------------------------------------------------------------------------

typedef logic signed [cbt_pkg::COORD_WIDTH_DEF-1:0] coord_type;

typedef struct packed {
   coord_type x;
   coord_type y;
   logic      seg_end;
} curve_pt_type;

class bezier_tracker;
   logic [cbt_pkg::N_WIDTH-1:0] intervals;
   longint                      held_x[3];
   longint                      held_y[3];
   int                          held_count;
   longint unsigned             wt[4];
   curve_pt_type                due_points[$];
   int                          errors;

   function new();
      intervals  = cbt_pkg::SAMPLES_RESET;
      held_count = 0;
      errors     = 0;
      foreach (held_x[k]) begin
         held_x[k] = 0;
         held_y[k] = 0;
      end
   endfunction

   function void set_intervals(logic [cbt_pkg::N_WIDTH-1:0] value);
      intervals = value;
   endfunction

   function int pending();
      return due_points.size();
   endfunction

   function coord_type blend(longint p0, longint p1, longint p2, longint p3);
      longint acc;
      longint q;
      longint hi;
      hi  = (longint'(1) <<< ($bits(coord_type) - 1)) - 1;
      acc = p0 * longint'(wt[0]) + p1 * longint'(wt[1])
          + p2 * longint'(wt[2]) + p3 * longint'(wt[3]);
      q = (acc + 32768) >>> 16;
      if (q > hi) q = hi;
      if (q < -hi - 1) q = -hi - 1;
      return coord_type'(q);
   endfunction

   // accepted request: store the point or expand a completed segment
   function void take_point(coord_type px, coord_type py, logic starts);
      longint unsigned n;
      longint unsigned t;
      longint unsigned u;
      longint unsigned half;
      curve_pt_type    pt;
      half = 64'd1 << 31;
      if (starts) begin
         held_x[0]  = longint'(px);
         held_y[0]  = longint'(py);
         held_count = 1;
         return;
      end
      if (held_count < 3) begin
         held_x[held_count] = longint'(px);
         held_y[held_count] = longint'(py);
         held_count++;
         return;
      end
      n = (intervals == 0) ? 64'd1 : 64'(intervals);
      for (longint unsigned i = 0; i <= n; i++) begin
         t = (i * 64'd65536 + n / 2) / n;
         u = 64'd65536 - t;
         wt[0] = (u * u * u + half) >> 32;
         wt[1] = (64'd3 * t * u * u + half) >> 32;
         wt[2] = (64'd3 * t * t * u + half) >> 32;
         wt[3] = (t * t * t + half) >> 32;
         pt.x       = blend(held_x[0], held_x[1], held_x[2], longint'(px));
         pt.y       = blend(held_y[0], held_y[1], held_y[2], longint'(py));
         pt.seg_end = (i == n);
         due_points.push_back(pt);
      end
      held_x[0]  = longint'(px);
      held_y[0]  = longint'(py);
      held_count = 1;
   endfunction

   function void match_sample(coord_type cx, coord_type cy, logic se);
      curve_pt_type want;
      if (due_points.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("curve point with none expected: x=%0d y=%0d end=%0b", cx, cy, se);
         return;
      end
      want = due_points.pop_front();
      if (want.x !== cx || want.y !== cy || want.seg_end !== se) begin
         errors++;
         if (errors <= 10)
            $display("curve point mismatch: expected x=%0d y=%0d end=%0b, got x=%0d y=%0d end=%0b",
                     want.x, want.y, want.seg_end, cx, cy, se);
      end
   endfunction
endclass

module cubic_bezier_trajectory_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int        CW            = cbt_pkg::COORD_WIDTH_DEF;
   localparam longint    CYCLE_LIMIT   = 2000000;
   localparam int        SETTLE_CYCLES = 24;
   localparam coord_type C_MAX         = {1'b0, {(CW-1){1'b1}}};
   localparam coord_type C_MIN         = {1'b1, {(CW-1){1'b0}}};

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        csr_we    = 1'b0;
   logic [cbt_pkg::N_WIDTH-1:0] csr_wdata = '0;
   bit                          idle_on   = 1'b0;
   int                          rsp_hold  = 0;
   longint                      cycle_count = 0;
   bezier_tracker               tracker   = new();

   cbt_req_if req_bus ();
   cbt_rsp_if rsp_bus ();

   cubic_bezier_trajectory_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL cubic_bezier_trajectory_core");
         $finish;
      end
   end

   // handshake monitors and result-side stall bursts
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         tracker.take_point(req_bus.point_x, req_bus.point_y, req_bus.starts_path);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.match_sample(rsp_bus.curve_x, rsp_bus.curve_y, rsp_bus.segment_end);
      if (rsp_hold > 0) begin
         rsp_hold      <= rsp_hold - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_hold      <= $urandom_range(0, 10);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_point(coord_type px, coord_type py, logic starts);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.point_x     <= px;
      req_bus.point_y     <= py;
      req_bus.starts_path <= starts;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_intervals(logic [cbt_pkg::N_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.set_intervals(value);
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0:       return C_MAX;
         1:       return C_MIN;
         2, 3:    return coord_type'(int'($urandom_range(0, 64)) - 32);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic random_points(int count);
      repeat (count) send_point(pick_coord(), pick_coord(), $urandom_range(0, 11) == 0);
   endtask

   logic [cbt_pkg::N_WIDTH-1:0] phase_n [6] = '{6'd3, 6'd0, 6'd8, 6'd63, 6'd5, 6'd2};

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.point_x     <= '0;
      req_bus.point_y     <= '0;
      req_bus.starts_path <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset interval count, no path start after reset
      send_point(20'sd1, 20'sd2, 1'b0);
      send_point(20'sd3, 20'sd4, 1'b0);
      send_point(20'sd5, -20'sd6, 1'b0);
      send_point(C_MAX, C_MIN, 1'b0);
      // partial segment dropped by a path start
      send_point(C_MIN, C_MAX, 1'b1);
      send_point(C_MAX, C_MAX, 1'b0);
      send_point(C_MAX, C_MAX, 1'b0);
      send_point(20'sd1, 20'sd1, 1'b1);
      // saturation at both ends
      send_point(C_MAX, C_MAX, 1'b1);
      send_point(C_MAX, C_MAX, 1'b0);
      send_point(C_MAX, C_MAX, 1'b0);
      send_point(C_MAX, C_MAX, 1'b0);
      send_point(C_MIN, C_MIN, 1'b1);
      send_point(C_MIN, C_MIN, 1'b0);
      send_point(C_MIN, C_MIN, 1'b0);
      send_point(C_MIN, C_MIN, 1'b0);
      drain_results();

      // zero interval count acts as one
      write_intervals(6'd0);
      send_point(20'sd100, -20'sd100, 1'b1);
      send_point(C_MAX, 20'sd0, 1'b0);
      send_point(C_MIN, 20'sd0, 1'b0);
      send_point(-20'sd7, 20'sd7, 1'b0);
      drain_results();

      write_intervals(6'd63);
      send_point(20'sd0, 20'sd0, 1'b0);
      send_point(C_MAX, C_MIN, 1'b0);
      send_point(C_MIN, C_MAX, 1'b0);
      drain_results();

      write_intervals(6'd1);
      send_point(20'sd16, -20'sd16, 1'b0);
      send_point(-20'sd16, 20'sd16, 1'b0);
      send_point(20'sd8, 20'sd8, 1'b0);
      drain_results();

      for (int p = 0; p < 6; p++) begin
         idle_on <= (p != 5);
         if (p == 4)
            write_intervals(6'($urandom_range(1, 63)));
         else
            write_intervals(phase_n[p]);
         if (p == 2) begin
            random_points(30);
            drain_results();
            random_points(30);
         end else begin
            random_points(60);
         end
         drain_results();
      end

      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("PASS cubic_bezier_trajectory_core");
      else
         $display("FAIL cubic_bezier_trajectory_core");
      $finish;
   end

endmodule

### sim.f
rtl/cbt_pkg.sv
rtl/cbt_channel_if.sv
rtl/cbt_ctrl.sv
rtl/cbt_datapath.sv
rtl/cubic_bezier_trajectory_core.sv
tb/cubic_bezier_trajectory_core_tb.sv
